### design/imuco_pkg.sv
// Shared types, constants and the step program of the IMU orientation block.
// Used by the interfaces, datapath, CORDIC unit, controller, top level and checker.
package imuco_pkg;

	localparam int ADDR_W = 4;
	localparam int CV_W   = 54;
	localparam int CZ_W   = 34;

	localparam logic [16:0] ALPHA_RESET   = 17'd64225;
	localparam logic [16:0] ALPHA_ONE     = 17'd65536;
	localparam logic [23:0] MAX_IV_RESET  = 24'd100000;
	localparam logic [23:0] DFLT_IV_RESET = 24'd10000;
	localparam logic [29:0] GYRO_GAIN     = 30'd716770142;
	localparam logic [29:0] INV_GAIN      = 30'd652032874;

	typedef enum logic [1:0] {
		REG_BLEND_ALPHA      = 2'd0,
		REG_MAX_INTERVAL     = 2'd1,
		REG_DEFAULT_INTERVAL = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [47:0]        timestamp_us;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [23:0] rate_x;
		logic signed [23:0] rate_y;
		logic signed [23:0] rate_z;
	} imu_in_t;

	typedef struct packed {
		logic signed [31:0] roll_angle;
		logic signed [31:0] pitch_angle;
		logic signed [31:0] yaw_angle;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} imu_out_t;

	typedef struct packed {
		logic [16:0] alpha;
		logic [23:0] max_iv;
		logic [23:0] dflt_iv;
	} cfg_t;

	typedef enum logic [4:0] {
		M_NONE, M_AYAY, M_AZAZ, M_RX_DT, M_RY_DT, M_RZ_DT, M_PH_G, M_PL_G,
		M_ALPHA_DR, M_ALPHA_DP, M_SR_CP, M_CR_SP, M_CR_CP, M_SR_SP,
		M_A1_CY, M_A2_SY, M_A2_CY, M_A1_SY, M_A3_SY, M_A4_CY, M_A3_CY, M_A4_SY
	} mul_sel_t;

	typedef enum logic [4:0] {
		W_NONE, W_SQ_SET, W_SQ_ADD, W_P, W_HI, W_INC_ROLL, W_INC_PITCH, W_INC_YAW,
		W_BL_ROLL, W_BL_PITCH, W_A1, W_A2, W_A3, W_A4,
		W_QX_SET, W_QX_SUB, W_QY_SET, W_QY_ADD, W_QZ_SET, W_QZ_SUB, W_QW_SET, W_QW_ADD
	} wb_sel_t;

	typedef enum logic [3:0] {
		X_NONE, X_DT, X_SQRT, X_ATAN_ROLL, X_ATAN_PITCH, X_SEED,
		X_SC_ROLL, X_SC_PITCH, X_SC_YAW, X_LOAD_OUT
	} xop_t;

	typedef struct packed {
		mul_sel_t msel;
		wb_sel_t  wsel;
		xop_t     xop;
	} prog_word_t;

	typedef struct packed {
		prog_word_t row;
		logic       fire;
		logic       capture;
	} cmd_t;

	typedef struct packed {
		logic acc_zero;
		logic unit_done;
	} stat_t;

	localparam int PC_W = 6;

	function automatic prog_word_t prog(input logic [PC_W-1:0] pc);
		prog_word_t w;
		w = '{M_NONE, W_NONE, X_NONE};
		case (pc)
			6'd0:  w = '{M_NONE, W_NONE, X_DT};
			6'd1:  w = '{M_AYAY, W_NONE, X_NONE};
			6'd2:  w = '{M_AZAZ, W_SQ_SET, X_NONE};
			6'd3:  w = '{M_NONE, W_SQ_ADD, X_NONE};
			6'd4:  w = '{M_NONE, W_NONE, X_SQRT};
			6'd5:  w = '{M_NONE, W_NONE, X_ATAN_ROLL};
			6'd6:  w = '{M_NONE, W_NONE, X_ATAN_PITCH};
			6'd7:  w = '{M_NONE, W_NONE, X_SEED};
			6'd8:  w = '{M_RX_DT, W_NONE, X_NONE};
			6'd9:  w = '{M_NONE, W_P, X_NONE};
			6'd10: w = '{M_PH_G, W_NONE, X_NONE};
			6'd11: w = '{M_PL_G, W_HI, X_NONE};
			6'd12: w = '{M_RY_DT, W_INC_ROLL, X_NONE};
			6'd13: w = '{M_NONE, W_P, X_NONE};
			6'd14: w = '{M_PH_G, W_NONE, X_NONE};
			6'd15: w = '{M_PL_G, W_HI, X_NONE};
			6'd16: w = '{M_RZ_DT, W_INC_PITCH, X_NONE};
			6'd17: w = '{M_NONE, W_P, X_NONE};
			6'd18: w = '{M_PH_G, W_NONE, X_NONE};
			6'd19: w = '{M_PL_G, W_HI, X_NONE};
			6'd20: w = '{M_NONE, W_INC_YAW, X_NONE};
			6'd21: w = '{M_ALPHA_DR, W_NONE, X_NONE};
			6'd22: w = '{M_ALPHA_DP, W_BL_ROLL, X_NONE};
			6'd23: w = '{M_NONE, W_BL_PITCH, X_NONE};
			6'd24: w = '{M_NONE, W_NONE, X_SC_ROLL};
			6'd25: w = '{M_NONE, W_NONE, X_SC_PITCH};
			6'd26: w = '{M_NONE, W_NONE, X_SC_YAW};
			6'd27: w = '{M_SR_CP, W_NONE, X_NONE};
			6'd28: w = '{M_CR_SP, W_A1, X_NONE};
			6'd29: w = '{M_CR_CP, W_A2, X_NONE};
			6'd30: w = '{M_SR_SP, W_A3, X_NONE};
			6'd31: w = '{M_A1_CY, W_A4, X_NONE};
			6'd32: w = '{M_A2_SY, W_QX_SET, X_NONE};
			6'd33: w = '{M_A2_CY, W_QX_SUB, X_NONE};
			6'd34: w = '{M_A1_SY, W_QY_SET, X_NONE};
			6'd35: w = '{M_A3_SY, W_QY_ADD, X_NONE};
			6'd36: w = '{M_A4_CY, W_QZ_SET, X_NONE};
			6'd37: w = '{M_A3_CY, W_QZ_SUB, X_NONE};
			6'd38: w = '{M_A4_SY, W_QW_SET, X_NONE};
			6'd39: w = '{M_NONE, W_QW_ADD, X_NONE};
			6'd40: w = '{M_NONE, W_NONE, X_LOAD_OUT};
			default: w = '{M_NONE, W_NONE, X_LOAD_OUT};
		endcase
		return w;
	endfunction

	function automatic logic [31:0] atan_entry(input logic [4:0] k);
		logic [31:0] a;
		a = '0;
		case (k)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			5'd30: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

### design/imuco_if.sv
// Valid/ready channels for IMU samples and orientation results.
// Depends on imuco_pkg for the payload types.
interface imuco_sample_if;
	logic                  valid;
	logic                  ready;
	imuco_pkg::imu_in_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface imuco_result_if;
	logic                  valid;
	logic                  ready;
	imuco_pkg::imu_out_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/imu_complementary_orientation.sv
// Top level of the complementary roll/pitch/yaw filter with APB register port.
// Depends on imuco_pkg, imuco_if, imuco_datapath and imuco_ctrl.
//
// One sample is taken at a time. For an item with nonzero acceleration the result
// is raised when the program ends, and the next sample can be taken in the same
// cycle. The work is done by the single shared CORDIC unit (two atan2 runs and
// three sin/cos runs), the 24-step square root and a single 33x33 multiplier
// used for all products (35 further program steps). An all-zero acceleration
// item gives no result. A finished result waits in the output register while
// the next sample is accepted and worked on.
// Registers: 0x0 blend_alpha, 0x4 max_interval_us, 0x8 default_interval_us.
module imu_complementary_orientation #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	imuco_sample_if.sink                   sample,
	imuco_result_if.source                 result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [imuco_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	imuco_pkg::cfg_t  cfg_q;
	imuco_pkg::cmd_t  cmd;
	imuco_pkg::stat_t status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha   <= imuco_pkg::ALPHA_RESET;
			cfg_q.max_iv  <= imuco_pkg::MAX_IV_RESET;
			cfg_q.dflt_iv <= imuco_pkg::DFLT_IV_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				imuco_pkg::REG_BLEND_ALPHA:      cfg_q.alpha   <= pwdata[16:0];
				imuco_pkg::REG_MAX_INTERVAL:     cfg_q.max_iv  <= pwdata[23:0];
				imuco_pkg::REG_DEFAULT_INTERVAL: cfg_q.dflt_iv <= pwdata[23:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			imuco_pkg::REG_BLEND_ALPHA:      prdata = {15'd0, cfg_q.alpha};
			imuco_pkg::REG_MAX_INTERVAL:     prdata = {8'd0, cfg_q.max_iv};
			imuco_pkg::REG_DEFAULT_INTERVAL: prdata = {8'd0, cfg_q.dflt_iv};
			default:                         prdata = '0;
		endcase
	end

	imuco_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.status    (status)
	);

	imuco_datapath #(.STEPS(CORDIC_STEPS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (sample.payload),
		.cfg      (cfg_q),
		.out_data (result.payload)
	);
endmodule

### design/imuco_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on imuco_pkg for widths and the arctangent table.
module imuco_cordic #(
	parameter int STEPS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              rot,
	input  logic signed [imuco_pkg::CV_W-1:0] x0,
	input  logic signed [imuco_pkg::CV_W-1:0] y0,
	input  logic signed [imuco_pkg::CZ_W-1:0] z0,
	output logic                              done,
	output logic signed [imuco_pkg::CV_W-1:0] x,
	output logic signed [imuco_pkg::CV_W-1:0] y,
	output logic signed [imuco_pkg::CZ_W-1:0] z
);
	localparam int IW = ($clog2(STEPS + 1) < 5) ? 5 : $clog2(STEPS + 1);

	logic                              busy_q, done_q, rot_q;
	logic [IW-1:0]                     iter_q;
	logic signed [imuco_pkg::CV_W-1:0] x_q, y_q, xs, ys;
	logic signed [imuco_pkg::CZ_W-1:0] z_q, a;
	logic                              dir;

	always_comb begin
		xs  = x_q >>> iter_q[4:0];
		ys  = y_q >>> iter_q[4:0];
		a   = $signed({{(imuco_pkg::CZ_W - 32){1'b0}}, imuco_pkg::atan_entry(iter_q[4:0])});
		dir = rot_q ? !z_q[imuco_pkg::CZ_W-1] : y_q[imuco_pkg::CV_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == IW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
			rot_q <= rot;
		end else if (busy_q) begin
			if (dir) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
endmodule

### design/imuco_isqrt.sv
// Bit-pair integer square root of a 48-bit value, one result bit per cycle.
// Standalone; no package dependency.
module imuco_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] v,
	output logic        done,
	output logic [23:0] root
);
	localparam logic [47:0] TOP_BIT = 48'h4000_0000_0000;

	logic        busy_q, done_q;
	logic [47:0] val_q, res_q, bit_q;
	logic [48:0] sum;

	assign sum = {1'b0, res_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= v;
			res_q <= '0;
			bit_q <= TOP_BIT;
		end else if (busy_q) begin
			if ({1'b0, val_q} >= sum) begin
				val_q <= val_q - sum[47:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[23:0];
endmodule

### design/imuco_datapath.sv
// Datapath: sample registers, filter state, shared multiplier, CORDIC and root units.
// Depends on imuco_pkg, imuco_cordic and imuco_isqrt.
module imuco_datapath #(
	parameter int STEPS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  imuco_pkg::cmd_t     cmd,
	output imuco_pkg::stat_t    status,
	input  imuco_pkg::imu_in_t  in_data,
	input  imuco_pkg::cfg_t     cfg,
	output imuco_pkg::imu_out_t out_data
);
	localparam int CV_W = imuco_pkg::CV_W;
	localparam int CZ_W = imuco_pkg::CZ_W;

	imuco_pkg::imu_in_t  in_q;
	imuco_pkg::imu_out_t out_q;

	logic [31:0]        roll_q, pitch_q, yaw_q, rollacc_q, pitchacc_q;
	logic [47:0]        prev_q, sumsq_q, p_q;
	logic               first_q, yz_q, xneg_q;
	logic [23:0]        dt_q, r_q;
	logic [39:0]        hi_q;
	logic signed [32:0] cr_q, sr_q, cp_q, sp_q, cy_q, sy_q;
	logic signed [32:0] a1_q, a2_q, a3_q, a4_q;
	logic signed [33:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [65:0] prod_q, rnd30, rnd16;
	logic signed [32:0] ma, mb, m30;
	logic [63:0]        gsum;
	logic [31:0]        inc;
	logic [16:0]        alpha_sat;
	logic [47:0]        tdiff;
	logic               dt_ok;

	logic                   c_start, c_rot, c_done, s_start, s_done;
	logic signed [CV_W-1:0] c_x0, c_y0, c_x, c_y;
	logic signed [CZ_W-1:0] c_z0, c_z;
	logic signed [26:0]     vx, vy, vxa, vya;
	logic signed [31:0]     ang;
	logic [23:0]            s_root;

	function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
		logic signed [33:0] t;
		logic signed [17:0] q;
		t = v + 34'sd32768;
		q = 18'(t >>> 16);
		if (q > 18'sd16384)
			return 16'sd16384;
		if (q < -18'sd16384)
			return -16'sd16384;
		return q[15:0];
	endfunction

	assign alpha_sat = (cfg.alpha > imuco_pkg::ALPHA_ONE) ? imuco_pkg::ALPHA_ONE : cfg.alpha;
	assign tdiff     = in_q.timestamp_us - prev_q;
	assign dt_ok     = (in_q.timestamp_us > prev_q) && (tdiff <= {24'd0, cfg.max_iv});
	assign rnd30     = prod_q + (66'sd1 <<< 29);
	assign m30       = 33'(rnd30 >>> 30);
	assign rnd16     = prod_q + 66'sd32768;
	assign gsum      = {hi_q, 24'd0} + prod_q[63:0] + 64'h8000_0000;
	assign inc       = gsum[63:32];

	assign status.acc_zero  = (in_q.accel_x == '0) && (in_q.accel_y == '0) && (in_q.accel_z == '0);
	assign status.unit_done = c_done | s_done;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.row.msel)
			imuco_pkg::M_AYAY: begin
				ma = 33'($signed(in_q.accel_y));
				mb = 33'($signed(in_q.accel_y));
			end
			imuco_pkg::M_AZAZ: begin
				ma = 33'($signed(in_q.accel_z));
				mb = 33'($signed(in_q.accel_z));
			end
			imuco_pkg::M_RX_DT: begin
				ma = 33'($signed(in_q.rate_x));
				mb = $signed({9'd0, dt_q});
			end
			imuco_pkg::M_RY_DT: begin
				ma = 33'($signed(in_q.rate_y));
				mb = $signed({9'd0, dt_q});
			end
			imuco_pkg::M_RZ_DT: begin
				ma = 33'($signed(in_q.rate_z));
				mb = $signed({9'd0, dt_q});
			end
			imuco_pkg::M_PH_G: begin
				ma = 33'($signed(p_q[47:24]));
				mb = $signed({3'd0, imuco_pkg::GYRO_GAIN});
			end
			imuco_pkg::M_PL_G: begin
				ma = $signed({9'd0, p_q[23:0]});
				mb = $signed({3'd0, imuco_pkg::GYRO_GAIN});
			end
			imuco_pkg::M_ALPHA_DR: begin
				ma = $signed({16'd0, alpha_sat});
				mb = 33'($signed(roll_q - rollacc_q));
			end
			imuco_pkg::M_ALPHA_DP: begin
				ma = $signed({16'd0, alpha_sat});
				mb = 33'($signed(pitch_q - pitchacc_q));
			end
			imuco_pkg::M_SR_CP: begin ma = sr_q; mb = cp_q; end
			imuco_pkg::M_CR_SP: begin ma = cr_q; mb = sp_q; end
			imuco_pkg::M_CR_CP: begin ma = cr_q; mb = cp_q; end
			imuco_pkg::M_SR_SP: begin ma = sr_q; mb = sp_q; end
			imuco_pkg::M_A1_CY: begin ma = a1_q; mb = cy_q; end
			imuco_pkg::M_A2_SY: begin ma = a2_q; mb = sy_q; end
			imuco_pkg::M_A2_CY: begin ma = a2_q; mb = cy_q; end
			imuco_pkg::M_A1_SY: begin ma = a1_q; mb = sy_q; end
			imuco_pkg::M_A3_SY: begin ma = a3_q; mb = sy_q; end
			imuco_pkg::M_A4_CY: begin ma = a4_q; mb = cy_q; end
			imuco_pkg::M_A3_CY: begin ma = a3_q; mb = cy_q; end
			imuco_pkg::M_A4_SY: begin ma = a4_q; mb = sy_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_comb begin
		vx    = '0;
		vy    = '0;
		ang   = '0;
		c_rot = 1'b0;
		case (cmd.row.xop)
			imuco_pkg::X_ATAN_ROLL: begin
				vy = 27'($signed(in_q.accel_y));
				vx = 27'($signed(in_q.accel_z));
			end
			imuco_pkg::X_ATAN_PITCH: begin
				vy = -(27'($signed(in_q.accel_x)) <<< 8);
				vx = $signed({3'd0, r_q});
			end
			imuco_pkg::X_SC_ROLL: begin
				ang   = $signed(roll_q);
				c_rot = 1'b1;
			end
			imuco_pkg::X_SC_PITCH: begin
				ang   = $signed(pitch_q);
				c_rot = 1'b1;
			end
			imuco_pkg::X_SC_YAW: begin
				ang   = $signed(yaw_q);
				c_rot = 1'b1;
			end
			default: begin
				vx = '0;
			end
		endcase
		vxa = vx[26] ? -vx : vx;
		vya = vx[26] ? -vy : vy;
		if (c_rot) begin
			c_x0 = $signed({{(CV_W - 30){1'b0}}, imuco_pkg::INV_GAIN});
			c_y0 = '0;
			c_z0 = CZ_W'(ang >>> 1);
		end else begin
			c_x0 = CV_W'(vxa) <<< 24;
			c_y0 = CV_W'(vya) <<< 24;
			c_z0 = vx[26] ? $signed({2'b00, 32'h8000_0000}) : '0;
		end
	end

	assign c_start = cmd.fire && ((cmd.row.xop == imuco_pkg::X_ATAN_ROLL) ||
		(cmd.row.xop == imuco_pkg::X_ATAN_PITCH) || c_rot);
	assign s_start = cmd.fire && (cmd.row.xop == imuco_pkg::X_SQRT);

	imuco_cordic #(.STEPS(STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (c_start),
		.rot    (c_rot),
		.x0     (c_x0),
		.y0     (c_y0),
		.z0     (c_z0),
		.done   (c_done),
		.x      (c_x),
		.y      (c_y),
		.z      (c_z)
	);

	imuco_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_start),
		.v      ({sumsq_q[31:0], 16'd0}),
		.done   (s_done),
		.root   (s_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q  <= '0;
			pitch_q <= '0;
			yaw_q   <= '0;
			prev_q  <= '0;
			first_q <= 1'b1;
		end else if (cmd.fire) begin
			case (cmd.row.wsel)
				imuco_pkg::W_INC_ROLL:  roll_q  <= roll_q + inc;
				imuco_pkg::W_INC_PITCH: pitch_q <= pitch_q + inc;
				imuco_pkg::W_INC_YAW:   yaw_q   <= yaw_q + inc;
				imuco_pkg::W_BL_ROLL:   roll_q  <= rollacc_q + rnd16[47:16];
				imuco_pkg::W_BL_PITCH:  pitch_q <= pitchacc_q + rnd16[47:16];
				default: begin
				end
			endcase
			case (cmd.row.xop)
				imuco_pkg::X_DT: prev_q <= in_q.timestamp_us;
				imuco_pkg::X_SEED: begin
					if (first_q) begin
						roll_q  <= rollacc_q;
						pitch_q <= pitchacc_q;
						yaw_q   <= '0;
						first_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			in_q <= in_data;
		if (cmd.fire && (cmd.row.msel != imuco_pkg::M_NONE))
			prod_q <= ma * mb;
		if (c_start) begin
			yz_q   <= (vy == '0);
			xneg_q <= vx[26];
		end
		if (cmd.fire) begin
			case (cmd.row.wsel)
				imuco_pkg::W_SQ_SET: sumsq_q <= prod_q[47:0];
				imuco_pkg::W_SQ_ADD: sumsq_q <= sumsq_q + prod_q[47:0];
				imuco_pkg::W_P:      p_q     <= prod_q[47:0];
				imuco_pkg::W_HI:     hi_q    <= prod_q[39:0];
				imuco_pkg::W_A1:     a1_q    <= m30;
				imuco_pkg::W_A2:     a2_q    <= m30;
				imuco_pkg::W_A3:     a3_q    <= m30;
				imuco_pkg::W_A4:     a4_q    <= m30;
				imuco_pkg::W_QX_SET: qx_q    <= 34'(m30);
				imuco_pkg::W_QX_SUB: qx_q    <= qx_q - 34'(m30);
				imuco_pkg::W_QY_SET: qy_q    <= 34'(m30);
				imuco_pkg::W_QY_ADD: qy_q    <= qy_q + 34'(m30);
				imuco_pkg::W_QZ_SET: qz_q    <= 34'(m30);
				imuco_pkg::W_QZ_SUB: qz_q    <= qz_q - 34'(m30);
				imuco_pkg::W_QW_SET: qw_q    <= 34'(m30);
				imuco_pkg::W_QW_ADD: qw_q    <= qw_q + 34'(m30);
				default: begin
				end
			endcase
			case (cmd.row.xop)
				imuco_pkg::X_DT: dt_q <= dt_ok ? tdiff[23:0] : cfg.dflt_iv;
				imuco_pkg::X_LOAD_OUT: begin
					out_q.roll_angle  <= $signed(roll_q);
					out_q.pitch_angle <= $signed(pitch_q);
					out_q.yaw_angle   <= $signed(yaw_q);
					out_q.quat_x      <= to_q14(qx_q);
					out_q.quat_y      <= to_q14(qy_q);
					out_q.quat_z      <= to_q14(qz_q);
					out_q.quat_w      <= to_q14(qw_q);
				end
				default: begin
				end
			endcase
		end
		if (s_done)
			r_q <= s_root;
		if (c_done) begin
			case (cmd.row.xop)
				imuco_pkg::X_ATAN_ROLL:
					rollacc_q <= yz_q ? (xneg_q ? 32'h8000_0000 : 32'd0) : c_z[31:0];
				imuco_pkg::X_ATAN_PITCH:
					pitchacc_q <= yz_q ? (xneg_q ? 32'h8000_0000 : 32'd0) : c_z[31:0];
				imuco_pkg::X_SC_ROLL: begin
					cr_q <= c_x[32:0];
					sr_q <= c_y[32:0];
				end
				imuco_pkg::X_SC_PITCH: begin
					cp_q <= c_x[32:0];
					sp_q <= c_y[32:0];
				end
				imuco_pkg::X_SC_YAW: begin
					cy_q <= c_x[32:0];
					sy_q <= c_y[32:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign out_data = out_q;
endmodule

### design/imuco_ctrl.sv
// Controller: steps through the program, waits on the iterative units, owns the handshakes.
// Depends on imuco_pkg for the program and command types.
module imuco_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output imuco_pkg::cmd_t  cmd,
	input  imuco_pkg::stat_t status
);
	typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

	state_t                     state_q;
	logic [imuco_pkg::PC_W-1:0] pc_q;
	logic                       out_valid_q;
	imuco_pkg::prog_word_t      row;
	logic                       fire;

	assign row = imuco_pkg::prog(pc_q);

	always_comb begin
		fire = 1'b0;
		if (state_q == S_RUN) begin
			case (row.xop) inside
				imuco_pkg::X_LOAD_OUT: fire = !out_valid_q;
				default:               fire = 1'b1;
			endcase
		end
	end

	assign cmd.row     = row;
	assign cmd.fire    = fire;
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
						pc_q    <= '0;
					end
				end
				S_RUN: begin
					case (row.xop) inside
						imuco_pkg::X_SQRT, imuco_pkg::X_ATAN_ROLL, imuco_pkg::X_ATAN_PITCH,
						imuco_pkg::X_SC_ROLL, imuco_pkg::X_SC_PITCH, imuco_pkg::X_SC_YAW:
							state_q <= S_WAIT;
						imuco_pkg::X_DT: begin
							if (status.acc_zero)
								state_q <= S_IDLE;
							else
								pc_q <= pc_q + 1'b1;
						end
						imuco_pkg::X_LOAD_OUT: begin
							if (!out_valid_q) begin
								out_valid_q <= 1'b1;
								state_q     <= S_IDLE;
							end
						end
						default: pc_q <= pc_q + 1'b1;
					endcase
				end
				S_WAIT: begin
					if (status.unit_done) begin
						pc_q    <= pc_q + 1'b1;
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/imuco_checker.sv
// Port-level checks for the orientation block, attached to the top level by bind.
// Depends on imuco_pkg for the result payload type.
module imuco_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input imuco_pkg::imu_out_t          out_payload,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [imuco_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                  pwdata,
	input logic [31:0]                  prdata
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a sample is still being worked on");

	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while the input side is still busy");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_payload)))
		else $error("pending result dropped or changed");

	a_alpha_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr == '0) |=>
		(paddr != '0 || prdata[16:0] == $past(pwdata[16:0])))
		else $error("blend weight readback differs from last write");
endmodule

bind imu_complementary_orientation imuco_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_payload (result.payload),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata)
);
